@@ hw/rtl/mgp_pkg.sv @@
// Shared constants, types and the elaborated Mercator table for the geo-to-pixel block.
`default_nettype none

package mgp_pkg;

  // Table geometry
  localparam int ADDR_BITS = 10;
  localparam int TBL_SIZE  = 1 << ADDR_BITS;
  localparam int STEP_SH   = 23 - ADDR_BITS;
  localparam int TBL_STEP  = 45 << STEP_SH;
  localparam int REM_W     = STEP_SH + 6;
  localparam int TW        = 44;
  localparam int M_W       = TW + 1;

  // Latitude limit, 85.0511287 degrees in 2^-22 degree units
  localparam int LAT_W     = 29;
  localparam logic [LAT_W-1:0] LAT_LIMIT = LAT_W'(356730289);

  // Reciprocals of 45 for constant division by multiplication
  localparam logic [63:0] RECIP_K  = ((64'd1 << 36) + 64'd44) / 64'd45;
  localparam logic [63:0] RECIP_C  = ((64'd1 << 32) + 64'd44) / 64'd45;
  localparam int          RK_W     = 31;
  localparam int          RC_W     = 27;

  // Interpolation product and quotient widths
  localparam int P_W       = 40 + REM_W + 1;
  localparam int N_W       = 48;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LINEAR_MODE = 3'd0,
    CFG_PPD         = 3'd1,
    CFG_PPR         = 3'd2,
    CFG_LON_OFFSET  = 3'd3,
    CFG_LAT_OFFSET  = 3'd4,
    CFG_VIEW_HEIGHT = 3'd5,
    CFG_CENTRE_LAT  = 3'd6,
    CFG_LAT_SLOPE   = 3'd7
  } cfg_idx_t;

  // Per-item side data that travels beside the table lookup
  typedef struct packed {
    logic [30:0] lon_mag;
    logic        lon_neg;
    logic [30:0] dl_mag;
    logic        dl_neg;
    logic        lat_neg;
    logic        clamped;
  } side_t;

  typedef logic [TW-1:0] tbl_t [TBL_SIZE];

  localparam logic [63:0] Q60_ONE    = 64'd1 << 60;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] LN2_Q64    = 64'hB17217F7D1CF79AC;

  // Q60 multiply, truncated
  function automatic logic [63:0] mulq60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // log2 of a positive Q60 value, signed Q56
  function automatic longint log2_q56(input logic [63:0] xin);
    logic [63:0] x;
    longint e;
    longint r;
    x = xin;
    e = 0;
    for (int i = 0; i < 4; i++) begin
      if (x >= (Q60_ONE << 1)) begin
        x = x >> 1;
        e = e + 1;
      end
    end
    for (int i = 0; i < 64; i++) begin
      if (x < Q60_ONE) begin
        x = x << 1;
        e = e - 1;
      end
    end
    r = e * (longint'(1) << 56);
    for (int i = 55; i >= 0; i--) begin
      x = mulq60(x, x);
      if (x >= (Q60_ONE << 1)) begin
        x = x >> 1;
        r = r + (longint'(1) << i);
      end
    end
    return r;
  endfunction

  // Build atanh(sin) over 0..90 degrees, unsigned Q40
  function automatic tbl_t build_tbl();
    tbl_t         t;
    logic [127:0] p;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  hi;
    longint       s;
    longint       c;
    longint       d;
    for (int k = 0; k < TBL_SIZE; k++) begin
      p  = 128'(k) * {64'd0, HALF_PI_Q60};
      x  = p[ADDR_BITS +: 64];
      x2 = mulq60(x, x);
      s = longint'(x);
      term = x;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          term = mulq60(term, x2) / 64'((2 * n) * (2 * n + 1));
          s = n[0] ? s - longint'(term) : s + longint'(term);
        end
      end
      c = longint'(Q60_ONE);
      term = Q60_ONE;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          term = mulq60(term, x2) / 64'((2 * n - 1) * (2 * n));
          c = n[0] ? c - longint'(term) : c + longint'(term);
        end
      end
      if (s < 0) s = 0;
      if (s > longint'(Q60_ONE)) s = longint'(Q60_ONE);
      if (c < (longint'(1) << 40)) c = longint'(1) << 40;
      if (c > longint'(Q60_ONE)) c = longint'(Q60_ONE);
      d = log2_q56(Q60_ONE + 64'(s)) - log2_q56(64'(c));
      if (d < 0) d = 0;
      p  = {64'd0, 64'(d)} * {64'd0, LN2_Q64};
      hi = p[127:64] + 64'd32768;
      t[k] = hi[16 +: TW];
    end
    return t;
  endfunction

  localparam tbl_t MERC_TBL = build_tbl();

endpackage

`default_nettype wire

@@ hw/rtl/mercator_geo_to_pixel.sv @@
// Top level: Web Mercator forward projection of one coordinate per beat.
// Throughput: one beat per cycle; the whole pipeline holds only while a finished
// pixel waits under pixel_stall.
// Reset: rst clears the stage valid bits and loads the configuration defaults.
`default_nettype none

module mercator_geo_to_pixel
  import mgp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               coord_valid,
  output logic                    coord_stall,
  input  wire logic signed [30:0] longitude,
  input  wire logic signed [29:0] latitude,
  output logic                    pixel_valid,
  input  wire logic               pixel_stall,
  output logic signed [55:0]      pixel_x,
  output logic signed [55:0]      pixel_y,
  output logic                    lat_clamped,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [55:0]        cfg_data
);

  localparam int NST = 11;

  // Latitude limit as a signed value for the clamp compares
  localparam logic signed [29:0] LAT_MAX = 30'(LAT_LIMIT);

  // Configuration registers
  logic               linear_mode;
  logic [47:0]        pixels_per_degree;
  logic [47:0]        pixels_per_radian;
  logic signed [55:0] lon_offset;
  logic signed [55:0] lat_offset;
  logic [15:0]        view_height;
  logic signed [29:0] centre_lat;
  logic [47:0]        lat_slope;

  logic [NST:1]       vld;
  logic               en;

  side_t              side_next;
  side_t              side [1:9];
  logic [LAT_W-1:0]   lat_abs1;
  logic [LAT_W-1:0]   lat_abs_next;
  logic [M_W-1:0]     m8;

  logic signed [29:0] lat_c;
  logic signed [30:0] dl;

  // Product stage
  logic [54:0]        px_lo;
  logic [54:0]        px_hi;
  logic [54:0]        pl_lo;
  logic [54:0]        pl_hi;
  logic [46:0]        pm_00;
  logic [46:0]        pm_01;
  logic [45:0]        pm_10;
  logic [45:0]        pm_11;

  logic [79:0]        xs;
  logic [79:0]        ls;
  logic [93:0]        ms;
  logic signed [57:0] xq;
  logic signed [57:0] lq;
  logic signed [57:0] mq;
  logic signed [57:0] x_next;
  logic signed [57:0] y_next;
  logic signed [57:0] x10;
  logic signed [57:0] y10;
  logic               clamped10;

  function automatic logic signed [55:0] sat56(input logic signed [57:0] v);
    if (v > 58'sh0_7F_FFFF_FFFF_FFFF) return 56'sh7F_FFFF_FFFF_FFFF;
    if (v < -58'sh0_80_0000_0000_0000) return 56'sh80_0000_0000_0000;
    return v[55:0];
  endfunction

  // Hold everything while a finished pixel is stalled
  always_comb begin
    en          = !(pixel_valid && pixel_stall);
    coord_stall = !en;
  end

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_mode       <= 1'b0;
      pixels_per_degree <= 48'd11930464;
      pixels_per_radian <= 48'd683565275;
      lon_offset        <= -56'sd8388608;
      lat_offset        <= -56'sd8388608;
      view_height       <= 16'd256;
      centre_lat        <= '0;
      lat_slope         <= 48'd11930464;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LINEAR_MODE: linear_mode       <= cfg_data[0];
        CFG_PPD:         pixels_per_degree <= cfg_data[47:0];
        CFG_PPR:         pixels_per_radian <= cfg_data[47:0];
        CFG_LON_OFFSET:  lon_offset        <= cfg_data;
        CFG_LAT_OFFSET:  lat_offset        <= cfg_data;
        CFG_VIEW_HEIGHT: view_height       <= cfg_data[15:0];
        CFG_CENTRE_LAT:  centre_lat        <= cfg_data[29:0];
        CFG_LAT_SLOPE:   lat_slope         <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], coord_valid};
    end
  end

  // Clamp latitude, take magnitudes
  always_comb begin
    side_next.clamped = 1'b0;
    lat_c = latitude;
    if (latitude > LAT_MAX) begin
      lat_c = LAT_MAX;
      side_next.clamped = 1'b1;
    end else if (latitude < -LAT_MAX) begin
      lat_c = -LAT_MAX;
      side_next.clamped = 1'b1;
    end
    dl = 31'(lat_c) - 31'(centre_lat);
    side_next.lon_neg = longitude[30];
    side_next.lon_mag = longitude[30] ? 31'(-longitude) : longitude;
    side_next.dl_neg  = dl[30];
    side_next.dl_mag  = dl[30] ? 31'(-dl) : dl;
    side_next.lat_neg = lat_c[29];
    lat_abs_next      = lat_c[29] ? LAT_W'(-lat_c) : LAT_W'(lat_c);
  end

  // Delay side data to meet the lookup result
  always_ff @(posedge clk) begin
    if (en) begin
      side[1]  <= side_next;
      lat_abs1 <= lat_abs_next;
      for (int i = 2; i <= 9; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  mgp_lookup u_lookup (
    .clk     (clk),
    .en      (en),
    .lat_abs (lat_abs1),
    .m       (m8)
  );

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      px_lo <= 55'(side[8].lon_mag) * 55'(pixels_per_degree[23:0]);
      px_hi <= 55'(side[8].lon_mag) * 55'(pixels_per_degree[47:24]);
      pl_lo <= 55'(side[8].dl_mag) * 55'(lat_slope[23:0]);
      pl_hi <= 55'(side[8].dl_mag) * 55'(lat_slope[47:24]);
      pm_00 <= 47'(m8[22:0]) * 47'(pixels_per_radian[23:0]);
      pm_01 <= 47'(m8[22:0]) * 47'(pixels_per_radian[47:24]);
      pm_10 <= 46'(m8[44:23]) * 46'(pixels_per_radian[23:0]);
      pm_11 <= 46'(m8[44:23]) * 46'(pixels_per_radian[47:24]);
    end
  end

  // Sum, round half away from zero, apply signs and offsets (no lat_offset in linear mode)
  always_comb begin
    xs = 80'(px_lo) + (80'(px_hi) << 24) + (80'd1 << 29);
    ls = 80'(pl_lo) + (80'(pl_hi) << 24) + (80'd1 << 29);
    ms = 94'(pm_00) + (94'(pm_01) << 24) + (94'(pm_10) << 23) + (94'(pm_11) << 47)
       + (94'd1 << 47);
    xq = 58'(xs[79:30]);
    lq = 58'(ls[79:30]);
    mq = 58'(ms[93:48]);
    if (side[9].lon_neg) xq = -xq;
    if (side[9].dl_neg)  lq = -lq;
    if (side[9].lat_neg) mq = -mq;
    x_next = xq - 58'(lon_offset);
    if (linear_mode) begin
      y_next = (58'(view_height) << 15) - lq;
    end else begin
      y_next = (58'(view_height) << 16) - mq + 58'(lat_offset);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x10       <= x_next;
      y10       <= y_next;
      clamped10 <= side[9].clamped;
    end
  end

  // Saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      pixel_x     <= sat56(x10);
      pixel_y     <= sat56(y10);
      lat_clamped <= clamped10;
    end
  end

  assign pixel_valid = vld[NST];

endmodule

`default_nettype wire

@@ hw/rtl/mgp_div45.sv @@
// One registered 16-bit digit step of a division by 45.
`default_nettype none

module mgp_div45
  import mgp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [5:0]  r_in,
  input  wire logic [15:0] chunk,
  output logic      [15:0] q,
  output logic      [5:0]  r_out
);

  logic [21:0]        num;
  logic [22+RC_W-1:0] prod;
  logic [15:0]        qd;
  logic [21:0]        back;

  // Estimate the digit by reciprocal, then form the remainder
  always_comb begin
    num  = {r_in, chunk};
    prod = (22+RC_W)'(num) * (22+RC_W)'(RECIP_C[RC_W-1:0]);
    qd   = prod[32 +: 16];
    back = 22'(qd) * 22'd45;
  end

  // Advance one digit
  always_ff @(posedge clk) begin
    if (en) begin
      q     <= qd;
      r_out <= 6'(num - back);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mgp_lookup.sv @@
// Pipelined interpolated lookup of atanh(sin(lat)) for a non-negative latitude.
`default_nettype none

module mgp_lookup
  import mgp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [LAT_W-1:0] lat_abs,
  output logic      [M_W-1:0]   m
);

  // Stage 1: coarse index product
  logic [LAT_W-1:0]      a1;
  logic [LAT_W+RK_W-1:0] kp1;
  // Stage 2: table read
  logic [TW-1:0]         t0_2;
  logic [TW-1:0]         t1_2;
  logic [REM_W-1:0]      rem2;
  // Stage 3: interpolation product
  logic [TW-1:0]         t0_3;
  logic [P_W-1:0]        p3;
  // Digit stages
  logic [TW-1:0]         t0_4;
  logic [TW-1:0]         t0_5;
  logic [TW-1:0]         t0_6;
  logic [31:0]           lo4;
  logic [15:0]           lo5;
  logic [15:0]           q4_hi;
  logic [15:0]           q5_hi;
  logic [15:0]           q5_mid;
  logic [15:0]           dq4;
  logic [15:0]           dq5;
  logic [15:0]           dq6;
  logic [5:0]            r4;
  logic [5:0]            r5;
  logic [5:0]            r6;

  logic [LAT_W-1:0]      qa;
  logic [23:0]           k2;
  logic [ADDR_BITS-1:0]  kc;
  logic [LAT_W:0]        base2;
  logic [REM_W-1:0]      rem_next;
  logic [TW-1:0]         diff_raw;
  logic [39:0]           diff;
  logic [P_W-1:0]        psum;
  logic [N_W-1:0]        n4;
  logic [47:0]           quot;

  // Divide the latitude by the table step
  always_comb begin
    qa = lat_abs >> STEP_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= lat_abs;
      kp1 <= (LAT_W+RK_W)'(qa) * (LAT_W+RK_W)'(RECIP_K[RK_W-1:0]);
    end
  end

  // Clamp the index near 90 degrees and form the remainder
  always_comb begin
    k2 = kp1[36 +: 24];
    if (k2 > 24'(TBL_SIZE - 2)) begin
      kc       = ADDR_BITS'(TBL_SIZE - 2);
      base2    = '0;
      rem_next = REM_W'(TBL_STEP);
    end else begin
      kc       = k2[ADDR_BITS-1:0];
      base2    = (LAT_W+1)'(k2) * (LAT_W+1)'(TBL_STEP);
      rem_next = REM_W'((LAT_W+1)'(a1) - base2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_2 <= MERC_TBL[kc];
      t1_2 <= MERC_TBL[kc + ADDR_BITS'(1)];
      rem2 <= rem_next;
    end
  end

  // Slope times remainder
  always_comb begin
    diff_raw = (t1_2 > t0_2) ? t1_2 - t0_2 : '0;
    diff     = (diff_raw > TW'(40'hFF_FFFF_FFFF)) ? 40'hFF_FFFF_FFFF : diff_raw[39:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_3 <= t0_2;
      p3   <= P_W'(diff) * P_W'(rem2);
    end
  end

  // Round, drop the power-of-two part of the step, then divide by 45 a digit at a time
  always_comb begin
    psum = p3 + P_W'(TBL_STEP / 2);
    n4   = N_W'(psum >> STEP_SH);
  end

  mgp_div45 u_div_hi (
    .clk   (clk),
    .en    (en),
    .r_in  (6'd0),
    .chunk (n4[47:32]),
    .q     (dq4),
    .r_out (r4)
  );

  mgp_div45 u_div_mid (
    .clk   (clk),
    .en    (en),
    .r_in  (r4),
    .chunk (lo4[31:16]),
    .q     (dq5),
    .r_out (r5)
  );

  mgp_div45 u_div_lo (
    .clk   (clk),
    .en    (en),
    .r_in  (r5),
    .chunk (lo5),
    .q     (dq6),
    .r_out (r6)
  );

  // Carry the low digits and the base entry beside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      t0_4   <= t0_3;
      lo4    <= n4[31:0];
      t0_5   <= t0_4;
      lo5    <= lo4[15:0];
      q4_hi  <= dq4;
      t0_6   <= t0_5;
      q5_hi  <= q4_hi;
      q5_mid <= dq5;
    end
  end

  // Add the interpolated step to the base entry
  always_comb begin
    quot = {q5_hi, q5_mid, dq6};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= M_W'(t0_6) + M_W'(quot[40:0]) + M_W'(r6 & 6'd0);
    end
  end

endmodule

`default_nettype wire
